[design/b64d_pkg.sv]
package b64d_pkg;

    // One input item: a character, or the end-of-string marker.
    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
    } char_item_t;

    // One result item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
        logic       status;
    } res_item_t;

    localparam int MAX_PUSH  = 3;
    localparam int OUT_DEPTH = 8;

    // The decode stage hands the output buffer zero to three results per cycle.
    typedef struct packed {
        logic [1:0]                 n;
        res_item_t [MAX_PUSH-1:0]   slot;
    } push_t;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_PAD   = 8'h3d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5a;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7a;
    localparam logic [7:0] CH_D0    = 8'h30;
    localparam logic [7:0] CH_D9    = 8'h39;

    localparam logic [5:0] SEXT_PLUS  = 6'd62;
    localparam logic [5:0] SEXT_SLASH = 6'd63;

    // Returns {bad, sextet}; a bad character gives sextet zero.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= CH_UP_A && c <= CH_UP_Z)
        begin
            d = c - CH_UP_A;
            return {1'b0, d[5:0]};
        end
        else if (c >= CH_LO_A && c <= CH_LO_Z)
        begin
            d = c - CH_LO_A + 8'd26;
            return {1'b0, d[5:0]};
        end
        else if (c >= CH_D0 && c <= CH_D9)
        begin
            d = c - CH_D0 + 8'd52;
            return {1'b0, d[5:0]};
        end
        else if (c == CH_PLUS)
        begin
            return {1'b0, SEXT_PLUS};
        end
        else if (c == CH_SLASH)
        begin
            return {1'b0, SEXT_SLASH};
        end
        return {1'b1, 6'd0};
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

endpackage

[design/base64_stream_decoder_core.sv]
// Streaming Base64 decoder, standard alphabet with '=' padding.
// Input channel char_valid / char_stall / char_item: one character per item,
// or an end-of-string marker (kind = 1). Blanks are skipped.
// Output channel res_valid / res_stall / res_item: one decoded byte per item;
// the final item of a string has last = 1 and carries the string status
// (1 = rejected, the consumer drops the bytes of that string). An empty string
// or one with nothing left to emit ends with a single item with has_byte = 0.
// An accepted character or end marker waits in the input register until the
// output buffer has room, is then decoded, and its results enter the buffer.
// Throughput: one input item per cycle. A completed group leaves as a burst of
// three result items through an eight-entry output buffer that drains one item
// per cycle unless stalled; input stalls only while it has fewer than three
// free entries, so four characters per three bytes keep pace with the output.
// Reset clears the decode state and empties the buffer; nothing is pending.
// When the receiver stalls, res_item holds; with under three free entries left,
// char_stall rises with one item kept in the input register.
module base64_stream_decoder_core #(
    parameter int OUT_DEPTH = b64d_pkg::OUT_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_stall,
    input  b64d_pkg::char_item_t char_item,
    output logic                 res_valid,
    input  logic                 res_stall,
    output b64d_pkg::res_item_t  res_item
);
    import b64d_pkg::*;

    push_t push;
    logic  room;

    b64d_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item),
        .room       (room),
        .push       (push)
    );

    b64d_outbuf #(
        .DEPTH (OUT_DEPTH)
    ) u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule

[design/b64d_decode.sv]
module b64d_decode (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_stall,
    input  b64d_pkg::char_item_t char_item,
    input  logic                 room,
    output b64d_pkg::push_t      push
);
    import b64d_pkg::*;

    logic       in_valid_reg, in_valid_next;
    char_item_t in_item_reg;

    logic [23:0] group_bits_reg, group_bits_next;
    logic [1:0]  group_pos_reg, group_pos_next;
    logic [1:0]  group_pad_reg, group_pad_next;
    logic [23:0] held_bits_reg, held_bits_next;
    logic [1:0]  held_pad_reg, held_pad_next;
    logic        held_valid_reg, held_valid_next;
    logic        error_reg, error_next;

    logic        accept;
    logic        fire;
    logic        status;
    logic        keep1;
    logic        keep2;
    logic [6:0]  sext;
    logic [5:0]  val;
    logic [23:0] shifted;
    logic [23:0] gbits;
    logic [1:0]  pad_after;

    assign char_stall = in_valid_reg && !room;
    assign accept     = char_valid && !char_stall;
    assign fire       = in_valid_reg && room;

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= char_item;
    end

    always_comb
    begin
        group_bits_next = group_bits_reg;
        group_pos_next  = group_pos_reg;
        group_pad_next  = group_pad_reg;
        held_bits_next  = held_bits_reg;
        held_pad_next   = held_pad_reg;
        held_valid_next = held_valid_reg;
        error_next      = error_reg;
        push            = '0;

        status    = error_reg || (group_pos_reg != 2'd0);
        keep1     = (group_pos_reg != 2'd0) || (held_pad_reg != 2'b11);
        keep2     = (group_pos_reg != 2'd0) || !held_pad_reg[1];
        sext      = sextet_of(in_item_reg.char_code);
        val       = 6'd0;
        shifted   = 24'd0;
        gbits     = 24'd0;
        pad_after = group_pad_reg;

        if (fire && in_item_reg.kind == KIND_END)
        begin
            if (held_valid_reg)
            begin
                push.slot[0] = '{held_bits_reg[23:16], 1'b1, !keep1 && !keep2,
                                 !keep1 && !keep2 && status};
                push.slot[1] = '{held_bits_reg[15:8], 1'b1, !keep2, !keep2 && status};
                push.slot[2] = '{held_bits_reg[7:0], 1'b1, 1'b1, status};
                push.n       = 2'd1 + {1'b0, keep1} + {1'b0, keep2};
            end
            else
            begin
                push.slot[0] = '{8'd0, 1'b0, 1'b1, status};
                push.n       = 2'd1;
            end
            group_bits_next = 24'd0;
            group_pos_next  = 2'd0;
            group_pad_next  = 2'd0;
            held_bits_next  = 24'd0;
            held_pad_next   = 2'd0;
            held_valid_next = 1'b0;
            error_next      = 1'b0;
        end
        else if (fire && !is_blank(in_item_reg.char_code))
        begin
            // a new character proves the held group was not the final one
            if (group_pos_reg == 2'd0 && held_valid_reg)
            begin
                push.slot[0]    = '{held_bits_reg[23:16], 1'b1, 1'b0, 1'b0};
                push.slot[1]    = '{held_bits_reg[15:8], 1'b1, 1'b0, 1'b0};
                push.slot[2]    = '{held_bits_reg[7:0], 1'b1, 1'b0, 1'b0};
                push.n          = 2'd3;
                held_valid_next = 1'b0;
            end

            if (in_item_reg.char_code == CH_PAD)
            begin
                if (!group_pos_reg[1])
                    error_next = 1'b1;
                else
                    pad_after[group_pos_reg[0]] = 1'b1;
            end
            else
            begin
                val = sext[5:0];
                if (sext[6])
                    error_next = 1'b1;
            end

            case (group_pos_reg)
                2'd0:    shifted = {val, 18'd0};
                2'd1:    shifted = {6'd0, val, 12'd0};
                2'd2:    shifted = {12'd0, val, 6'd0};
                default: shifted = {18'd0, val};
            endcase
            gbits = group_bits_reg | shifted;

            if (group_pos_reg == 2'd3)
            begin
                held_bits_next  = gbits;
                held_pad_next   = pad_after;
                held_valid_next = 1'b1;
                group_bits_next = 24'd0;
                group_pad_next  = 2'd0;
                group_pos_next  = 2'd0;
            end
            else
            begin
                group_bits_next = gbits;
                group_pad_next  = pad_after;
                group_pos_next  = group_pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_bits_reg <= 24'd0;
            group_pos_reg  <= 2'd0;
            group_pad_reg  <= 2'd0;
            held_bits_reg  <= 24'd0;
            held_pad_reg   <= 2'd0;
            held_valid_reg <= 1'b0;
            error_reg      <= 1'b0;
        end
        else
        begin
            group_bits_reg <= group_bits_next;
            group_pos_reg  <= group_pos_next;
            group_pad_reg  <= group_pad_next;
            held_bits_reg  <= held_bits_next;
            held_pad_reg   <= held_pad_next;
            held_valid_reg <= held_valid_next;
            error_reg      <= error_next;
        end
    end

`ifndef ASSERT_OFF
    // an end marker leaves a clean string state behind
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_item_reg.kind == KIND_END |=>
            group_pos_reg == 2'd0 && !held_valid_reg && !error_reg)
        else $error("state not cleared after end of string");

    // every end marker yields at least one result, the last one flagged
    a_end_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_item_reg.kind == KIND_END |->
            push.n != 2'd0 && push.slot[push.n - 2'd1].last)
        else $error("end of string without a last result");

    // a group's fourth character always ends up held
    a_group_held: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_item_reg.kind == KIND_CHAR && !is_blank(in_item_reg.char_code)
            && group_pos_reg == 2'd3 |=> held_valid_reg && group_pos_reg == 2'd0)
        else $error("completed group not held");
`endif

endmodule

[design/b64d_outbuf.sv]
module b64d_outbuf #(
    parameter int DEPTH = b64d_pkg::OUT_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  b64d_pkg::push_t     push,
    output logic                room,
    output logic                res_valid,
    input  logic                res_stall,
    output b64d_pkg::res_item_t res_item
);
    import b64d_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    res_item_t mem [DEPTH];

    logic [AW-1:0] rptr_reg, rptr_next;
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW:0]   idx_sum [MAX_PUSH];
    logic [AW-1:0] idx [MAX_PUSH];
    logic [AW:0]   wsum;
    logic          pop;

    assign pop       = res_valid && !res_stall;
    assign res_valid = (count_reg != '0);
    assign res_item  = mem[rptr_reg];
    assign room      = (CW'(DEPTH) - count_reg) >= CW'(MAX_PUSH);

    always_comb
    begin
        for (int i = 0; i < MAX_PUSH; i++)
        begin
            idx_sum[i] = {1'b0, wptr_reg} + (AW+1)'(i);
            if (idx_sum[i] >= (AW+1)'(DEPTH))
                idx_sum[i] = idx_sum[i] - (AW+1)'(DEPTH);
            idx[i] = idx_sum[i][AW-1:0];
        end

        wsum = {1'b0, wptr_reg} + (AW+1)'(push.n);
        if (wsum >= (AW+1)'(DEPTH))
            wsum = wsum - (AW+1)'(DEPTH);
        wptr_next = wsum[AW-1:0];

        if (pop)
            rptr_next = (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + AW'(1);
        else
            rptr_next = rptr_reg;

        count_next = count_reg + CW'(push.n) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_PUSH; i++)
        begin
            if (2'(i) < push.n)
                mem[idx[i]] <= push.slot[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rptr_reg  <= '0;
            wptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            rptr_reg  <= rptr_next;
            wptr_reg  <= wptr_next;
            count_reg <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.n != 2'd0 |-> (CW'(DEPTH) - count_reg) >= CW'(push.n))
        else $error("output buffer overflow");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("output buffer count out of range");

    // a stalled result item stays offered and unchanged
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_item))
        else $error("result item changed while stalled");
`endif

endmodule
